@@ rtl/sorted_polynomial_term_adder_unit_macros.svh @@
// Assertion macros shared by the checker of the sorted polynomial term adder.
`ifndef SORTED_POLYNOMIAL_TERM_ADDER_UNIT_MACROS_SVH
`define SORTED_POLYNOMIAL_TERM_ADDER_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPTA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPTA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/spta_pkg.sv @@
// Types and constants shared by the sorted polynomial term adder modules.
package spta_pkg;

  localparam int unsigned COEF_W = 32;
  localparam int unsigned EXP_W  = 10;

  typedef enum logic [1:0] {
    MODE_LOAD_FIRST  = 2'd0,
    MODE_LOAD_SECOND = 2'd1,
    MODE_ADD         = 2'd2,
    MODE_NONE        = 2'd3
  } spta_mode_e;

  typedef enum logic [1:0] {
    ST_TERM      = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_LOAD_OK   = 2'd2,
    ST_LOAD_FULL = 2'd3
  } spta_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_LOAD_RESP,
    S_MERGE,
    S_EMPTY_RESP
  } spta_state_e;

  typedef struct packed {
    spta_mode_e                mode;
    logic signed [COEF_W-1:0]  coefficient;
    logic        [EXP_W-1:0]   exponent;
  } spta_in_t;

  typedef struct packed {
    logic signed [COEF_W-1:0]  result_coefficient;
    logic        [EXP_W-1:0]   result_exponent;
    logic                      last_term;
    spta_status_e              status;
  } spta_out_t;

  typedef struct packed {
    logic signed [COEF_W-1:0]  coef;
    logic        [EXP_W-1:0]   expo;
  } spta_term_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start_load;
    logic start_merge;
    logic ins_step;
    logic load_resp;
    logic merge_step;
    logic empty_resp;
  } spta_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic ins_done;
    logic merge_last;
    logic both_empty;
    logic out_free;
  } spta_stat_t;

endpackage

@@ rtl/sorted_polynomial_term_adder_unit.sv @@
// Top level of the sorted polynomial term adder: controller plus datapath.
//
//   Channel | Direction | Handshake                 | Payload
//   --------+-----------+---------------------------+---------------------------
//   in      | input     | in_valid_i / in_stall_o   | in_data_i  (spta_in_t)
//   out     | output    | out_valid_o / out_stall_i | out_data_o (spta_out_t)
//
// A load is accepted, then insertion steps on the store's single write port shift each stored term
// with a smaller exponent up one place and write the new term, then it answers; a load into a full
// store is dropped and only answered. An add is accepted, then emits one term per merge step, as
// the merge walks both stores one read port each; an add with both stores empty only answers.
// Reset clears both term counts and all control state; stored terms are not cleared.
// Output stalls hold the answer or merge step; a finished result may wait while the next starts.
module sorted_polynomial_term_adder_unit import spta_pkg::*; #(
  parameter int unsigned TERMS_PER_POLY = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  spta_in_t   in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output spta_out_t  out_data_o
);

  // Commands and status are the only link between the controller and the datapath.
  spta_cmd_t  cmd;
  spta_stat_t stat;

  // The controller sequences loads (insertion walk, then answer) and adds (merge walk, or the empty answer).
  spta_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_mode_i  (in_data_i.mode),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  // The datapath holds both sorted term stores, their pointers and the output register.
  spta_dp #(
    .TERMS_PER_POLY (TERMS_PER_POLY)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_stall_i (out_stall_i),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

@@ rtl/spta_ctrl.sv @@
// Controller state machine of the sorted polynomial term adder.
module spta_ctrl import spta_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  spta_mode_e  in_mode_i,
  input  spta_stat_t  stat_i,
  output spta_cmd_t   cmd_o,
  output logic        in_stall_o
);

  spta_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          unique case (in_mode_i) inside
            MODE_LOAD_FIRST, MODE_LOAD_SECOND: begin
              state_d = stat_i.full ? S_LOAD_RESP : S_INSERT;
            end
            MODE_ADD: begin
              state_d = stat_i.both_empty ? S_EMPTY_RESP : S_MERGE;
            end
            MODE_NONE: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_INSERT: begin
        if (stat_i.ins_done) state_d = S_LOAD_RESP;
      end
      S_LOAD_RESP: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      S_MERGE: begin
        if (stat_i.out_free && stat_i.merge_last) state_d = S_IDLE;
      end
      S_EMPTY_RESP: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          unique case (in_mode_i) inside
            MODE_LOAD_FIRST, MODE_LOAD_SECOND: cmd_o.start_load = 1'b1;
            MODE_ADD:                          cmd_o.start_merge = 1'b1;
            MODE_NONE:                         cmd_o = '0;
          endcase
        end
      end
      S_INSERT:     cmd_o.ins_step   = 1'b1;
      S_LOAD_RESP:  cmd_o.load_resp  = stat_i.out_free;
      S_MERGE:      cmd_o.merge_step = stat_i.out_free;
      S_EMPTY_RESP: cmd_o.empty_resp = stat_i.out_free;
      default:      cmd_o = '0;
    endcase
  end

endmodule

@@ rtl/spta_dp.sv @@
// Datapath of the sorted polynomial term adder: term stores, pointers and output register.
module spta_dp import spta_pkg::*; #(
  parameter int unsigned TERMS_PER_POLY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  spta_in_t    in_data_i,
  input  spta_cmd_t   cmd_i,
  input  logic        out_stall_i,
  output spta_stat_t  stat_o,
  output logic        out_valid_o,
  output spta_out_t   out_data_o
);

  localparam int unsigned IDX_W = (TERMS_PER_POLY > 1) ? $clog2(TERMS_PER_POLY) : 1;
  localparam int unsigned CNT_W = $clog2(TERMS_PER_POLY + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TERMS_PER_POLY);
  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  spta_term_t mem_a_q [TERMS_PER_POLY];
  spta_term_t mem_b_q [TERMS_PER_POLY];
  spta_term_t rd_a_q, rd_b_q;

  logic [CNT_W-1:0] cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [CNT_W-1:0] ia_q, ia_d, ib_q, ib_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic             sel_q, sel_d;
  logic             ins_q, ins_d;
  logic             drop_q, drop_d;
  spta_term_t       term_q, term_d;
  logic             out_valid_q, out_valid_d;
  spta_out_t        out_q, out_d;

  logic                  load_sel_second;
  logic [CNT_W-1:0]      cnt_sel;
  spta_term_t            rd_sel;
  logic                  ins_done;
  logic                  a_has, b_has, exp_eq, take_a, ia_inc, ib_inc;
  logic [CNT_W-1:0]      ia_nxt, ib_nxt;
  logic                  merge_last;
  logic signed [COEF_W:0] sum_wide;
  logic signed [COEF_W-1:0] sum_sat, merge_coef;
  logic [EXP_W-1:0]      merge_exp;
  logic                  out_free, out_load;
  logic [IDX_W-1:0]      ins_addr, addr_a, addr_b;
  logic                  we_a, we_b;
  spta_term_t            wdata;

  assign load_sel_second = (in_data_i.mode == MODE_LOAD_SECOND);
  assign cnt_sel         = load_sel_second ? cnt_b_q : cnt_a_q;
  assign rd_sel          = sel_q ? rd_b_q : rd_a_q;

  // Insertion walks down from the end; it stops at the first term not below the new one.
  assign ins_done = (ptr_q == '0) || (rd_sel.expo >= term_q.expo);

  assign a_has  = (ia_q < cnt_a_q);
  assign b_has  = (ib_q < cnt_b_q);
  assign exp_eq = a_has && b_has && (rd_a_q.expo == rd_b_q.expo);
  assign take_a = !b_has || (a_has && (rd_a_q.expo > rd_b_q.expo));
  assign ia_inc = exp_eq || take_a;
  assign ib_inc = exp_eq || !take_a;
  assign ia_nxt = ia_q + CNT_W'(ia_inc);
  assign ib_nxt = ib_q + CNT_W'(ib_inc);
  assign merge_last = (ia_nxt == cnt_a_q) && (ib_nxt == cnt_b_q);

  always_comb begin
    sum_wide = {rd_a_q.coef[COEF_W-1], rd_a_q.coef} + {rd_b_q.coef[COEF_W-1], rd_b_q.coef};
    if (sum_wide[COEF_W] != sum_wide[COEF_W-1]) begin
      sum_sat = sum_wide[COEF_W] ? COEF_MIN : COEF_MAX;
    end else begin
      sum_sat = sum_wide[COEF_W-1:0];
    end
    if (exp_eq) begin
      merge_coef = sum_sat;
      merge_exp  = rd_a_q.expo;
    end else if (take_a) begin
      merge_coef = rd_a_q.coef;
      merge_exp  = rd_a_q.expo;
    end else begin
      merge_coef = rd_b_q.coef;
      merge_exp  = rd_b_q.expo;
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = cmd_i.load_resp || cmd_i.merge_step || cmd_i.empty_resp;

  always_comb begin
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    ia_d    = ia_q;
    ib_d    = ib_q;
    ptr_d   = ptr_q;
    sel_d   = sel_q;
    ins_d   = ins_q;
    drop_d  = drop_q;
    term_d  = term_q;
    if (cmd_i.start_load) begin
      sel_d       = load_sel_second;
      term_d.coef = in_data_i.coefficient;
      term_d.expo = in_data_i.exponent;
      drop_d      = stat_o.full;
      ins_d       = !stat_o.full;
      ptr_d       = cnt_sel[IDX_W-1:0];
    end
    if (cmd_i.ins_step) begin
      if (ins_done) begin
        ins_d = 1'b0;
        if (sel_q) cnt_b_d = cnt_b_q + CNT_W'(1);
        else       cnt_a_d = cnt_a_q + CNT_W'(1);
      end else begin
        ptr_d = ptr_q - IDX_W'(1);
      end
    end
    if (cmd_i.start_merge) begin
      ia_d = '0;
      ib_d = '0;
    end
    if (cmd_i.merge_step) begin
      ia_d = ia_nxt;
      ib_d = ib_nxt;
      if (merge_last) begin
        cnt_a_d = '0;
        cnt_b_d = '0;
      end
    end
  end

  // Read data always follows the next pointer value, so it is valid for the pointer register.
  assign ins_addr = (ptr_d == '0) ? '0 : ptr_d - IDX_W'(1);
  assign addr_a = (ins_d && !sel_d) ? ins_addr :
                  ((ia_d < CNT_FULL) ? ia_d[IDX_W-1:0] : '0);
  assign addr_b = (ins_d && sel_d) ? ins_addr :
                  ((ib_d < CNT_FULL) ? ib_d[IDX_W-1:0] : '0);
  assign we_a  = cmd_i.ins_step && !sel_q;
  assign we_b  = cmd_i.ins_step && sel_q;
  assign wdata = ins_done ? term_q : rd_sel;

  always_ff @(posedge clk_i) begin
    if (we_a) mem_a_q[ptr_q] <= wdata;
    rd_a_q <= mem_a_q[addr_a];
  end

  always_ff @(posedge clk_i) begin
    if (we_b) mem_b_q[ptr_q] <= wdata;
    rd_b_q <= mem_b_q[addr_b];
  end

  always_comb begin
    out_d                    = '0;
    out_d.result_coefficient = '0;
    out_d.result_exponent    = '0;
    out_d.last_term          = 1'b1;
    out_d.status             = ST_EMPTY;
    if (cmd_i.load_resp) begin
      out_d.status = drop_q ? ST_LOAD_FULL : ST_LOAD_OK;
    end else if (cmd_i.merge_step) begin
      out_d.result_coefficient = merge_coef;
      out_d.result_exponent    = merge_exp;
      out_d.last_term          = merge_last;
      out_d.status             = ST_TERM;
    end
  end

  always_comb begin
    if (out_load)         out_valid_d = 1'b1;
    else if (out_stall_i) out_valid_d = out_valid_q;
    else                  out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      ia_q        <= '0;
      ib_q        <= '0;
      ptr_q       <= '0;
      sel_q       <= 1'b0;
      ins_q       <= 1'b0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_a_q     <= cnt_a_d;
      cnt_b_q     <= cnt_b_d;
      ia_q        <= ia_d;
      ib_q        <= ib_d;
      ptr_q       <= ptr_d;
      sel_q       <= sel_d;
      ins_q       <= ins_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    term_q <= term_d;
    if (out_load) out_q <= out_d;
  end

  assign stat_o.full       = load_sel_second ? (cnt_b_q == CNT_FULL) : (cnt_a_q == CNT_FULL);
  assign stat_o.ins_done   = ins_done;
  assign stat_o.merge_last = merge_last;
  assign stat_o.both_empty = (cnt_a_q == '0) && (cnt_b_q == '0);
  assign stat_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ rtl/spta_checker.sv @@
// Port-level checker of the sorted polynomial term adder, bound to the top level.
`include "sorted_polynomial_term_adder_unit_macros.svh"

module spta_checker import spta_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input spta_in_t   in_data_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input spta_out_t  out_data_o
);

  `SPTA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
                    out_valid_o && $stable(out_data_o), "stalled result transaction changed")
  `SPTA_ASSERT_NOW(a_answer_fields, clk_i, rst_ni,
                   out_valid_o && (out_data_o.status != ST_TERM),
                   out_data_o.last_term && (out_data_o.result_coefficient == '0) &&
                   (out_data_o.result_exponent == '0),
                   "answer transaction has nonzero term fields")
  `SPTA_ASSERT_NOW(a_last_only_terms, clk_i, rst_ni, out_valid_o && !out_data_o.last_term,
                   out_data_o.status == ST_TERM, "non-final result is not a merged term")
  `SPTA_ASSERT_NEXT(a_busy_after_item, clk_i, rst_ni,
                    in_valid_i && !in_stall_o && (in_data_i.mode != MODE_NONE),
                    in_stall_o, "input not stalled after a working transaction")
  `SPTA_ASSERT_NEXT(a_idle_after_none, clk_i, rst_ni,
                    in_valid_i && !in_stall_o && (in_data_i.mode == MODE_NONE),
                    !in_stall_o, "unused mode started work")

endmodule

bind sorted_polynomial_term_adder_unit spta_checker u_spta_checker (.*);

@@ test/tb_sorted_polynomial_term_adder_unit.sv @@
// Self-checking testbench for the sorted polynomial term adder unit.
module tb_sorted_polynomial_term_adder_unit;
  import spta_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TERMS_PER_POLY = 16;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 32'sh8000_0000;
  // Longest stretch with no transaction on either channel before the run is abandoned.
  localparam int unsigned QUIET_LIMIT = 1000;
  // Cycles the receiver refuses results during the back-pressure test.
  localparam int unsigned HOLD_CYCLES = 80;
  // Settling cycles after the last result, longer than the slowest insertion.
  localparam int unsigned TAIL_CYCLES = 40;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  spta_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  spta_out_t out_data_o;

  sorted_polynomial_term_adder_unit #(
    .TERMS_PER_POLY(TERMS_PER_POLY)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of both term stores; index 0 is the first polynomial, 1 the second.
  spta_term_t  poly_terms[2][TERMS_PER_POLY];
  int unsigned poly_count[2];
  // Results still owed by the block, oldest first.
  spta_out_t   expected_terms[$];

  int unsigned error_count;
  int unsigned items_sent;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_asked;
  int unsigned hold_served;
  int unsigned hold_left;
  int unsigned quiet_cycles;

  initial begin
    error_count    = 0;
    items_sent     = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_asked     = 0;
    hold_served    = 0;
    hold_left      = 0;
    quiet_cycles   = 0;
    poly_count[0]  = 0;
    poly_count[1]  = 0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic void owe_result(logic signed [COEF_W-1:0] coef, logic [EXP_W-1:0] expo,
                                     logic last, spta_status_e status);
    spta_out_t r;
    r.result_coefficient = coef;
    r.result_exponent    = expo;
    r.last_term          = last;
    r.status             = status;
    expected_terms.push_back(r);
  endfunction

  // Coefficient sum clipped to the Q16.16 range.
  function automatic logic signed [COEF_W-1:0] saturated_sum(logic signed [COEF_W-1:0] a,
                                                             logic signed [COEF_W-1:0] b);
    logic signed [COEF_W:0] wide;
    wide = (COEF_W+1)'(a) + (COEF_W+1)'(b);
    if (wide[COEF_W] != wide[COEF_W-1]) begin
      return wide[COEF_W] ? COEF_MIN : COEF_MAX;
    end
    return wide[COEF_W-1:0];
  endfunction

  // Applies one accepted transaction to the shadow stores and queues the results it owes.
  function automatic void compute_expected_terms(spta_in_t item);
    int unsigned sel, pos, i, ia, ib, na, nb;
    logic signed [COEF_W-1:0] coef;
    logic [EXP_W-1:0] expo;
    case (item.mode) inside
      MODE_LOAD_FIRST, MODE_LOAD_SECOND: begin
        sel = (item.mode == MODE_LOAD_SECOND) ? 1 : 0;
        if (poly_count[sel] >= TERMS_PER_POLY) begin
          owe_result('0, '0, 1'b1, ST_LOAD_FULL);
        end else begin
          // A new term lands after every stored term of greater or equal exponent.
          pos = 0;
          while (pos < poly_count[sel] && poly_terms[sel][pos].expo >= item.exponent) pos++;
          for (i = poly_count[sel]; i > pos; i--) poly_terms[sel][i] = poly_terms[sel][i-1];
          poly_terms[sel][pos].coef = item.coefficient;
          poly_terms[sel][pos].expo = item.exponent;
          poly_count[sel]++;
          owe_result('0, '0, 1'b1, ST_LOAD_OK);
        end
      end
      MODE_ADD: begin
        na = poly_count[0];
        nb = poly_count[1];
        if (na == 0 && nb == 0) begin
          owe_result('0, '0, 1'b1, ST_EMPTY);
        end else begin
          ia = 0;
          ib = 0;
          while (ia < na || ib < nb) begin
            if (ia < na && ib < nb && poly_terms[0][ia].expo == poly_terms[1][ib].expo) begin
              coef = saturated_sum(poly_terms[0][ia].coef, poly_terms[1][ib].coef);
              expo = poly_terms[0][ia].expo;
              ia++;
              ib++;
            end else if (ib >= nb ||
                         (ia < na && poly_terms[0][ia].expo > poly_terms[1][ib].expo)) begin
              coef = poly_terms[0][ia].coef;
              expo = poly_terms[0][ia].expo;
              ia++;
            end else begin
              coef = poly_terms[1][ib].coef;
              expo = poly_terms[1][ib].expo;
              ib++;
            end
            owe_result(coef, expo, (ia >= na && ib >= nb), ST_TERM);
          end
          poly_count[0] = 0;
          poly_count[1] = 0;
        end
      end
      default: ;  // The unused mode leaves everything as it was.
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off whenever the test asks for one.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      out_stall_i <= 1'b1;
      hold_served <= hold_asked;
      hold_left   <= HOLD_CYCLES - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result is matched against the oldest expectation.
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin : check_results
    spta_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_terms.size() == 0) begin
        $display("%0t: unexpected result coef=%0d exp=%0d last=%0b status=%0d", $time,
                 out_data_o.result_coefficient, out_data_o.result_exponent,
                 out_data_o.last_term, out_data_o.status);
        error_count++;
      end else begin
        want = expected_terms.pop_front();
        if (out_data_o.result_coefficient !== want.result_coefficient ||
            out_data_o.result_exponent !== want.result_exponent ||
            out_data_o.last_term !== want.last_term ||
            out_data_o.status !== want.status) begin
          $display({"%0t: mismatch expected coef=%0d exp=%0d last=%0b status=%0d, ",
                    "actual coef=%0d exp=%0d last=%0b status=%0d"},
                   $time, want.result_coefficient, want.result_exponent, want.last_term,
                   want.status, out_data_o.result_coefficient, out_data_o.result_exponent,
                   out_data_o.last_term, out_data_o.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long with no transaction on either channel means the block is hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offers one transaction after a random idle gap and returns at the edge that takes it.
  // Valid stays high on return, so a following call can offer the next one back to back.
  task automatic send_item(spta_in_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    compute_expected_terms(item);
    if (item.mode != MODE_NONE) items_sent++;
  endtask

  task automatic send_load(spta_mode_e mode, logic signed [COEF_W-1:0] coef,
                           logic [EXP_W-1:0] expo);
    spta_in_t item;
    item.mode        = mode;
    item.coefficient = coef;
    item.exponent    = expo;
    send_item(item);
  endtask

  // Coefficient and exponent of an add are don't-care, so they carry random bits.
  task automatic send_add();
    send_load(MODE_ADD, $urandom(), EXP_W'($urandom()));
  endtask

  // Drops valid and waits for every owed result; sampled on the falling edge so the
  // checker's update at the rising edge has settled.
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_terms.size() != 0);
    @(posedge clk_i);
  endtask

  function automatic logic signed [COEF_W-1:0] pick_coefficient();
    case ($urandom_range(5))
      0:       return COEF_MAX - $urandom_range(3);
      1:       return COEF_MIN + $urandom_range(3);
      2:       return $urandom_range(131072) - 65536;
      default: return $urandom();
    endcase
  endfunction

  // Mostly short polynomials; now and then a full store or an overflowing one.
  function automatic int unsigned pick_size();
    case ($urandom_range(9))
      0, 1:    return $urandom_range(TERMS_PER_POLY, 7);
      2:       return $urandom_range(TERMS_PER_POLY + 2, TERMS_PER_POLY);
      default: return $urandom_range(6);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // An add with both stores empty answers one empty-sum result.
  task automatic test_empty_add();
    send_add();
  endtask

  // The unused mode is taken and produces nothing.
  task automatic test_ignored_mode();
    send_load(MODE_NONE, $urandom(), EXP_W'($urandom()));
  endtask

  // Coefficient and exponent extremes, saturation both ways, a zero sum, equal exponents
  // inside one store, and a term present in only one store.
  task automatic test_extreme_terms();
    send_load(MODE_LOAD_FIRST, COEF_MAX, 10'd1023);
    send_load(MODE_LOAD_FIRST, COEF_MIN, 10'd0);
    send_load(MODE_LOAD_FIRST, 32'sd5, 10'd7);
    send_load(MODE_LOAD_FIRST, 32'sd3, 10'd7);
    send_load(MODE_LOAD_SECOND, COEF_MAX, 10'd1023);
    send_load(MODE_LOAD_SECOND, -32'sd1, 10'd0);
    send_load(MODE_LOAD_SECOND, -32'sd5, 10'd7);
    send_load(MODE_LOAD_SECOND, 32'sh0001_2345, 10'd512);
    send_add();
    send_load(MODE_LOAD_SECOND, 32'sh0001_0000, 10'd3);
    send_add();
  endtask

  // Fills the first store, overflows it by one, then merges it with an empty second store.
  task automatic test_full_store();
    int unsigned n;
    for (n = 0; n <= TERMS_PER_POLY; n++) begin
      send_load(MODE_LOAD_FIRST, pick_coefficient(), EXP_W'($urandom_range(1023)));
    end
    send_add();
  endtask

  // One round of well-formed traffic: fill both stores in random order, then add.
  // Now and then an ignored item slips in or the add is left out.
  task automatic random_round();
    int unsigned n_first, n_second, span;
    spta_in_t    item;
    n_first  = pick_size();
    n_second = pick_size();
    case ($urandom_range(2))
      0:       span = 4;
      1:       span = 32;
      default: span = 1024;
    endcase
    while (n_first + n_second != 0) begin
      if ($urandom_range(19) == 0) begin
        item.mode        = MODE_NONE;
        item.coefficient = $urandom();
        item.exponent    = EXP_W'($urandom());
        send_item(item);
      end
      if (n_second == 0 || (n_first != 0 && $urandom_range(1) == 0)) begin
        item.mode = MODE_LOAD_FIRST;
        n_first--;
      end else begin
        item.mode = MODE_LOAD_SECOND;
        n_second--;
      end
      item.coefficient = pick_coefficient();
      item.exponent    = EXP_W'($urandom_range(span - 1));
      send_item(item);
    end
    if ($urandom_range(6) != 0) send_add();
  endtask

  task automatic test_random_traffic(int unsigned count, int unsigned idle_pct,
                                     int unsigned stall_pct);
    int unsigned target;
    target         = items_sent + count;
    send_idle_pct  = idle_pct;
    recv_stall_pct <= stall_pct;
    while (items_sent < target) random_round();
  endtask

  // The receiver holds off for a long stretch while loads keep coming, so the block's
  // output fills and it stalls the input; then a merge flushes what was loaded.
  task automatic test_backpressure();
    int unsigned n;
    send_idle_pct = 0;
    hold_asked   <= hold_asked + 1;
    for (n = 0; n < 20; n++) begin
      send_load(n[0] ? MODE_LOAD_SECOND : MODE_LOAD_FIRST, pick_coefficient(),
                EXP_W'($urandom_range(63)));
    end
    send_add();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_add();
    test_ignored_mode();
    test_extreme_terms();
    test_full_store();
    test_backpressure();
    wait_results_drained();

    test_random_traffic(130, 20, 48);
    wait_results_drained();
    test_random_traffic(130, 48, 20);
    wait_results_drained();
    test_random_traffic(120, 0, 0);

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && expected_terms.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/spta_pkg.sv
rtl/spta_ctrl.sv
rtl/spta_dp.sv
rtl/sorted_polynomial_term_adder_unit.sv
rtl/spta_checker.sv
test/tb_sorted_polynomial_term_adder_unit.sv
